// ----- hdl/bitmap_page_frame_allocator_defines.svh -----
// Assertion macros used by the allocator RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define BPFA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BPFA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bpfa_pkg.sv -----
// Constants and types of the bitmap page frame allocator.
package bpfa_pkg;

   localparam int NUM_PAGES_DEF   = 65536;
   localparam int FRAME_SHIFT_DEF = 12;

   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 80;
   localparam int ADDR_W      = 40;
   localparam int COUNT_W     = 17;

   localparam logic [31:0] REGION_AVAILABLE = 32'd1;

   typedef enum logic [2:0] {
      OP_BEGIN     = 3'd0,
      OP_ADD       = 3'd1,
      OP_FINISH    = 3'd2,
      OP_ALLOC_ONE = 3'd3,
      OP_FREE_ONE  = 3'd4,
      OP_ALLOC_RUN = 3'd5,
      OP_FREE_RUN  = 3'd6,
      OP_NOP       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      M_ALLOC1  = 3'd0,
      M_RUNSCAN = 3'd1,
      M_TAKE    = 3'd2,
      M_FREE    = 3'd3,
      M_ADD     = 3'd4,
      M_FINISH  = 3'd5
   } mode_type;

   typedef enum logic [5:0] {
      S_SWEEP = 6'b000001,
      S_IDLE  = 6'b000010,
      S_PREP  = 6'b000100,
      S_RUN   = 6'b001000,
      S_WAIT  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

endpackage

// ----- hdl/bitmap_page_frame_allocator.sv -----
// Bitmap page frame allocator with a word cache over a one-port-pair bitmap memory.
// A command ends in the done state, which registers the result; a walk runs frames and loads missed words.
// Frame walks cover up to NUM_PAGES frames, and about twice that for a run allocation.
// Begin setup sweeps the bitmap memory and sets every bitmap word.
// After reset a sweep pass marks every frame used; no word is taken.
// One command is in progress at a time; a new one is taken once the result register is empty or read.
`include "bitmap_page_frame_allocator_defines.svh"
module bitmap_page_frame_allocator #(
   parameter int NUM_PAGES   = bpfa_pkg::NUM_PAGES_DEF,
   parameter int FRAME_SHIFT = bpfa_pkg::FRAME_SHIFT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // op[2:0], address[42:3], region_length[82:43], region_type[114:83], page_count[131:115]
   input  logic [bpfa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // page_address[39:0], ok[40], free_count[57:41], total_count[74:58]
   output logic [bpfa_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import bpfa_pkg::*;

   localparam int FRAME_W   = $clog2(NUM_PAGES);
   localparam int CNT_W     = $clog2(NUM_PAGES + 1);
   localparam int WORD_W    = (FRAME_W > 6) ? FRAME_W - 6 : 1;
   localparam int MAP_WORDS = (NUM_PAGES + 63) / 64;
   localparam int RUN_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int WIDE_W    = ADDR_W + 1;
   localparam logic [WIDE_W-1:0] UNIT_M1 = WIDE_W'((64'd1 << FRAME_SHIFT) - 64'd1);

   logic [63:0]        map_mem [MAP_WORDS];
   logic [63:0]        rdata_ff;
   logic               mem_we;
   logic [WORD_W-1:0]  mem_waddr;
   logic [63:0]        mem_wdata;
   logic [WORD_W-1:0]  mem_raddr;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [WORD_W-1:0]  sweep_ff, sweep_in;
   logic               pend_ff, pend_in;
   logic               pass_ff, pass_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]   hint_ff, hint_in;
   logic [CNT_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   lim_ff, lim_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WIDE_W-1:0]  first_ff, first_in;
   logic [WIDE_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]   res_frame_ff, res_frame_in;
   logic               res_ok_ff, res_ok_in;
   logic               wvalid_ff, wvalid_in;
   logic [WORD_W-1:0]  widx_ff, widx_in;
   logic [63:0]        wbuf_ff, wbuf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   op_type             req_op;
   logic [ADDR_W-1:0]  req_address;
   logic [ADDR_W-1:0]  req_length;
   logic [31:0]        req_type;
   logic [COUNT_W-1:0] req_count;
   logic               accept;
   logic [5:0]         bitpos;
   logic               hit;
   logic               bitv;
   logic [WIDE_W-1:0]  cap;
   logic [WIDE_W-1:0]  limw;
   logic [RUN_W-1:0]   start;
   logic [63:0]        paddr;

   assign req_op      = op_type'(req_tdata[2:0]);
   assign req_address = req_tdata[42:3];
   assign req_length  = req_tdata[82:43];
   assign req_type    = req_tdata[114:83];
   assign req_count   = req_tdata[131:115];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign bitpos    = cur_ff[5:0];
   assign mem_raddr = WORD_W'(cur_ff >> 6);
   assign hit       = wvalid_ff && (widx_ff == mem_raddr);
   assign bitv      = wbuf_ff[bitpos];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      pass_in      = pass_ff;
      total_in     = total_ff;
      free_in      = free_ff;
      hint_in      = hint_ff;
      cur_in       = cur_ff;
      lim_in       = lim_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      res_frame_in = res_frame_ff;
      res_ok_in    = res_ok_ff;
      wvalid_in    = wvalid_ff;
      widx_in      = widx_ff;
      wbuf_in      = wbuf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = widx_ff;
      mem_wdata    = wbuf_ff;
      cap          = '0;
      limw         = '0;
      start        = '0;
      paddr        = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '1;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == WORD_W'(MAP_WORDS - 1)) begin
               state_in = pend_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               res_frame_in = '0;
               res_ok_in    = 1'b1;
               count_in     = req_count;
               pass_in      = 1'b0;
               run_in       = '0;
               unique case (req_op)
                  OP_BEGIN: begin
                     free_in   = '0;
                     total_in  = '0;
                     wvalid_in = 1'b0;
                     sweep_in  = '0;
                     pend_in   = 1'b1;
                     state_in  = S_SWEEP;
                  end
                  OP_ADD: begin
                     if (req_type == REGION_AVAILABLE && req_length != '0) begin
                        first_in = ({1'b0, req_address} + UNIT_M1) >> FRAME_SHIFT;
                        end_in   = ({1'b0, req_address} + {1'b0, req_length}) >> FRAME_SHIFT;
                        mode_in  = M_ADD;
                        state_in = S_PREP;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_FINISH: begin
                     if (total_ff != '0) begin
                        cur_in   = '0;
                        lim_in   = CNT_W'(1);
                        mode_in  = M_FINISH;
                        state_in = S_RUN;
                     end else begin
                        hint_in  = CNT_W'(1);
                        state_in = S_DONE;
                     end
                  end
                  OP_ALLOC_ONE, OP_ALLOC_RUN: begin
                     if (req_op == OP_ALLOC_ONE || req_count == COUNT_W'(1)) begin
                        cur_in   = hint_ff;
                        lim_in   = total_ff;
                        mode_in  = M_ALLOC1;
                        state_in = S_RUN;
                     end else if (req_count == '0) begin
                        res_ok_in = 1'b0;
                        state_in  = S_DONE;
                     end else begin
                        cur_in   = CNT_W'(1);
                        lim_in   = total_ff;
                        mode_in  = M_RUNSCAN;
                        state_in = S_RUN;
                     end
                  end
                  OP_FREE_ONE, OP_FREE_RUN: begin
                     first_in = {1'b0, req_address} >> FRAME_SHIFT;
                     end_in   = ({1'b0, req_address} >> FRAME_SHIFT) +
                                ((req_op == OP_FREE_ONE) ? WIDE_W'(1) : WIDE_W'(req_count));
                     mode_in  = M_FREE;
                     state_in = S_PREP;
                  end
                  default: begin
                     res_ok_in = 1'b0;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_PREP: begin
            cap      = (mode_ff == M_ADD) ? WIDE_W'(NUM_PAGES) : WIDE_W'(total_ff);
            limw     = (end_ff < cap) ? end_ff : cap;
            lim_in   = CNT_W'(limw);
            cur_in   = (first_ff < limw) ? CNT_W'(first_ff) : CNT_W'(limw);
            state_in = S_RUN;
         end
         S_RUN: begin
            if (cur_ff >= lim_ff) begin
               unique case (mode_ff)
                  M_ALLOC1: begin
                     if (!pass_ff) begin
                        pass_in = 1'b1;
                        cur_in  = CNT_W'(1);
                        lim_in  = (hint_ff < total_ff) ? hint_ff : total_ff;
                     end else begin
                        res_ok_in = 1'b0;
                        state_in  = S_DONE;
                     end
                  end
                  M_RUNSCAN: begin
                     res_ok_in = 1'b0;
                     state_in  = S_DONE;
                  end
                  M_ADD: begin
                     if (lim_ff > total_ff) begin
                        total_in = lim_ff;
                     end
                     state_in = S_DONE;
                  end
                  M_FINISH: begin
                     hint_in  = CNT_W'(1);
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else if (!hit) begin
               state_in = S_WAIT;
            end else begin
               cur_in = cur_ff + 1'b1;
               unique case (mode_ff)
                  M_ALLOC1: begin
                     if (!bitv) begin
                        wbuf_in      = wbuf_ff | (64'd1 << bitpos);
                        mem_we       = 1'b1;
                        mem_wdata    = wbuf_in;
                        free_in      = (free_ff != '0) ? free_ff - 1'b1 : '0;
                        hint_in      = cur_ff + 1'b1;
                        res_frame_in = cur_ff;
                        state_in     = S_DONE;
                     end
                  end
                  M_RUNSCAN: begin
                     if (!bitv) begin
                        run_in = run_ff + 1'b1;
                        if (run_ff + 1'b1 == RUN_W'(count_ff)) begin
                           start        = RUN_W'(cur_ff) + 1'b1 - RUN_W'(count_ff);
                           cur_in       = CNT_W'(start);
                           lim_in       = cur_ff + 1'b1;
                           res_frame_in = CNT_W'(start);
                           mode_in      = M_TAKE;
                        end
                     end else begin
                        run_in = '0;
                     end
                  end
                  M_TAKE, M_FINISH: begin
                     if (!bitv) begin
                        wbuf_in   = wbuf_ff | (64'd1 << bitpos);
                        mem_we    = 1'b1;
                        mem_wdata = wbuf_in;
                        free_in   = (free_ff != '0) ? free_ff - 1'b1 : '0;
                     end
                  end
                  M_FREE, M_ADD: begin
                     if (bitv) begin
                        wbuf_in   = wbuf_ff & ~(64'd1 << bitpos);
                        mem_we    = 1'b1;
                        mem_wdata = wbuf_in;
                        free_in   = free_ff + 1'b1;
                        if (mode_ff == M_FREE && cur_ff < hint_ff) begin
                           hint_in = cur_ff;
                        end
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WAIT: begin
            wbuf_in   = rdata_ff;
            widx_in   = mem_raddr;
            wvalid_in = 1'b1;
            state_in  = S_RUN;
         end
         S_DONE: begin
            paddr        = res_ok_ff ? (64'(res_frame_ff) << FRAME_SHIFT) : 64'd0;
            rsp_data_in  = {5'd0, COUNT_W'(total_ff), COUNT_W'(free_ff), res_ok_ff,
                            paddr[ADDR_W-1:0]};
            rsp_valid_in = 1'b1;
            pend_in      = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         free_ff      <= '0;
         hint_ff      <= '0;
         wvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         hint_ff      <= hint_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      pass_ff      <= pass_in;
      cur_ff       <= cur_in;
      lim_ff       <= lim_in;
      run_ff       <= run_in;
      count_ff     <= count_in;
      first_ff     <= first_in;
      end_ff       <= end_in;
      res_frame_ff <= res_frame_in;
      res_ok_ff    <= res_ok_in;
      widx_ff      <= widx_in;
      wbuf_ff      <= wbuf_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `BPFA_ASSERT(a_free_within_total, clock, reset, (state_ff == S_IDLE) |-> (free_ff <= total_ff), "free count above total")
   `BPFA_ASSERT(a_wait_after_run, clock, reset, (state_ff == S_WAIT) |-> ($past(state_ff) == S_RUN), "word load outside frame walk")
   `BPFA_ASSERT(a_result_from_done, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE), "result raised outside done")

endmodule
